// File: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared sizes, entry type, control group and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int unsigned DEPTH = 16;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	localparam int unsigned TAG_W   = 16;
	localparam int unsigned AGE_W   = 8;
	localparam int unsigned PRIO_W  = 8;
	localparam int unsigned COUNT_W = 5;

	typedef struct packed {
		logic              valid;
		logic [TAG_W-1:0]  tag;
		logic [AGE_W-1:0]  age;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// Operation applied to the whole row in the cycle a word is accepted.
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL_DROP = 2'd1,
		ST_EMPTY_POP = 2'd2
	} status_t;

	typedef enum logic {
		KIND_PUSH = 1'b0,
		KIND_POP  = 1'b1
	} kind_t;

endpackage

// File: hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted row: keeps, takes from its left or right
// neighbour, or captures the new entry.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  spq_pkg::entry_t    new_entry,
	input  spq_pkg::entry_t    left_entry,
	input  logic               left_keep,
	input  spq_pkg::entry_t    right_entry,
	output spq_pkg::entry_t    entry,
	output logic               keep
);

	logic                      valid_q;
	logic [spq_pkg::TAG_W-1:0]  tag_q;
	logic [spq_pkg::AGE_W-1:0]  age_q;
	logic [spq_pkg::PRIO_W-1:0] prio_q;
	logic                      goes_after;
	spq_pkg::entry_t           nxt;
	logic                      load;

	// The held entry is served after the new one when its priority number is
	// larger, or equal with a smaller age. Equal entries stay ahead (FIFO).
	always_comb begin
		if (prio_q != new_entry.prio) begin
			goes_after = prio_q > new_entry.prio;
		end else begin
			goes_after = age_q < new_entry.age;
		end
	end

	assign keep = valid_q && !goes_after;

	always_comb begin
		nxt  = right_entry;
		load = 1'b0;
		if (ctrl.pop) begin
			nxt  = right_entry;
			load = 1'b1;
		end else if (ctrl.push && !keep) begin
			load = 1'b1;
			if (!left_keep) begin
				nxt = left_entry;
			end else begin
				nxt       = new_entry;
				nxt.valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tag_q  <= nxt.tag;
			age_q  <= nxt.age;
			prio_q <= nxt.prio;
		end
	end

	assign entry = '{valid: valid_q, tag: tag_q, age: age_q, prio: prio_q};

endmodule

// File: hdl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded priority queue held as a row of cells in sorted order, head first.
// ----------------------------------------------------------------------------
//
// Channel  | Direction | Contents
// ---------+-----------+------------------------------------------------------
// s_*      | in        | one push or pop word; tuser = kind
// m_*      | out       | head entry, count and status after that word
//
// Every accepted word is handled at once: all cells compare the
// new entry with their own at once and either keep, shift or capture, so a
// word may be accepted in every cycle that the output side allows. Its result
// appears in the cycle after, held in an output register; a new word is
// accepted whenever that register is empty or is being drained in the same
// cycle. Reset empties the queue and the output register at once; no sweep.
//
module sorted_priority_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // entry_tag[15:0], entry_age[23:16], entry_priority[31:24]
	input  logic [0:0]  s_tuser,  // kind[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // head_valid[0], head_tag[16:1], head_age[24:17],
	                              // head_priority[32:25], entry_count[37:33], status[39:38]
);

	logic                        accept;
	logic                        full;
	logic                        empty;
	logic                        is_pop;
	spq_pkg::cell_ctrl_t         ctrl;
	spq_pkg::entry_t             new_entry;
	spq_pkg::entry_t             cell_entry [spq_pkg::DEPTH];
	logic                        cell_keep  [spq_pkg::DEPTH];
	logic                        out_valid_q;
	spq_pkg::status_t            status_q;
	logic [spq_pkg::CNT_W-1:0]   count_q;
	logic [spq_pkg::CNT_W+4:0]   count_ext;
	spq_pkg::entry_t             head;

	// A word is taken when the result register is free or being emptied.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign full   = count_q == spq_pkg::CNT_W'(spq_pkg::DEPTH);
	assign empty  = count_q == '0;
	assign is_pop = s_tuser[0] == spq_pkg::KIND_POP;

	// A push to a full queue and a pop of an empty one leave the row untouched.
	assign ctrl.push = accept && !is_pop && !full;
	assign ctrl.pop  = accept && is_pop && !empty;

	assign new_entry = '{valid: 1'b1, tag: s_tdata[15:0], age: s_tdata[23:16],
		prio: s_tdata[31:24]};

	// The row of cells. Cell 0 is the head; the left neighbour of cell 0 is
	// treated as kept so that it captures the new entry when it must move.
	// The cell beyond the tail reads as empty when popping.
	for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
		spq_pkg::entry_t left_e;
		spq_pkg::entry_t right_e;
		logic            left_k;

		if (i == 0) begin : g_first
			assign left_e = new_entry;
			assign left_k = 1'b1;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign left_k = cell_keep[i-1];
		end

		if (i == spq_pkg::DEPTH - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_entry   (new_entry),
			.left_entry  (left_e),
			.left_keep   (left_k),
			.right_entry (right_e),
			.entry       (cell_entry[i]),
			.keep        (cell_keep[i])
		);
	end

	// Count and status of the most recent word; the head is read straight
	// from cell 0, which only changes when the next word is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
			status_q    <= spq_pkg::ST_DONE;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				if (is_pop) begin
					status_q <= empty ? spq_pkg::ST_EMPTY_POP : spq_pkg::ST_DONE;
				end else begin
					status_q <= full ? spq_pkg::ST_FULL_DROP : spq_pkg::ST_DONE;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (ctrl.push) begin
				count_q <= count_q + spq_pkg::CNT_W'(1);
			end else if (ctrl.pop) begin
				count_q <= count_q - spq_pkg::CNT_W'(1);
			end
		end
	end

	// An empty queue reports a zero head.
	assign head      = cell_entry[0].valid ? cell_entry[0] : '0;
	assign count_ext = {5'd0, count_q};

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {status_q, count_ext[4:0], head.prio, head.age, head.tag, head.valid};

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Sends push and pop words into the queue and checks every reported head
// entry, count and status against a behavioural copy of the sorted queue.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Head report expected for one accepted word.
	typedef struct {
		logic                        head_valid;
		logic [spq_pkg::TAG_W-1:0]   head_tag;
		logic [spq_pkg::AGE_W-1:0]   head_age;
		logic [spq_pkg::PRIO_W-1:0]  head_prio;
		logic [spq_pkg::COUNT_W-1:0] count;
		spq_pkg::status_t            status;
	} head_report_t;

	// Behavioural copy of the queue plus the reports still awaited.
	class queue_scoreboard;
		logic [spq_pkg::TAG_W-1:0]  held_tag[spq_pkg::DEPTH];
		logic [spq_pkg::AGE_W-1:0]  held_age[spq_pkg::DEPTH];
		logic [spq_pkg::PRIO_W-1:0] held_prio[spq_pkg::DEPTH];
		int unsigned                held = 0;
		head_report_t               awaited[$];
		int                         errors = 0;

		// Applies one accepted word to the copy and queues the report it causes.
		function void note_word(spq_pkg::kind_t kind, logic [31:0] data);
			logic [spq_pkg::TAG_W-1:0]  tag;
			logic [spq_pkg::AGE_W-1:0]  age;
			logic [spq_pkg::PRIO_W-1:0] prio;
			int unsigned                pos;
			head_report_t               rep;
			tag  = data[15:0];
			age  = data[23:16];
			prio = data[31:24];
			rep.status = spq_pkg::ST_DONE;
			if (kind == spq_pkg::KIND_PUSH) begin
				if (held >= spq_pkg::DEPTH) begin
					rep.status = spq_pkg::ST_FULL_DROP;
				end else begin
					// Skip every entry served no later than the new one: lower
					// priority number, or equal number and at least as old.
					pos = 0;
					while (pos < held && !(held_prio[pos] > prio ||
						(held_prio[pos] == prio && held_age[pos] < age)))
						pos++;
					for (int unsigned k = held; k > pos; k--) begin
						held_tag[k]  = held_tag[k-1];
						held_age[k]  = held_age[k-1];
						held_prio[k] = held_prio[k-1];
					end
					held_tag[pos]  = tag;
					held_age[pos]  = age;
					held_prio[pos] = prio;
					held++;
				end
			end else begin
				if (held == 0) begin
					rep.status = spq_pkg::ST_EMPTY_POP;
				end else begin
					for (int unsigned k = 0; k + 1 < held; k++) begin
						held_tag[k]  = held_tag[k+1];
						held_age[k]  = held_age[k+1];
						held_prio[k] = held_prio[k+1];
					end
					held--;
				end
			end
			rep.head_valid = (held > 0);
			rep.head_tag   = (held > 0) ? held_tag[0] : '0;
			rep.head_age   = (held > 0) ? held_age[0] : '0;
			rep.head_prio  = (held > 0) ? held_prio[0] : '0;
			rep.count      = held[spq_pkg::COUNT_W-1:0];
			awaited.push_back(rep);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$display("%0t ns: %s mismatch, expected %h, actual %h",
					$time, name, want, got);
				errors++;
			end
		endfunction

		// Compares one delivered report with the oldest one awaited.
		function void check_result(logic [39:0] data);
			head_report_t rep;
			if (awaited.size() == 0) begin
				$display("%0t ns: unexpected result word, expected none, actual %h",
					$time, data);
				errors++;
				return;
			end
			rep = awaited.pop_front();
			compare_field("head_valid", 16'(rep.head_valid), 16'(data[0]));
			compare_field("head_tag", 16'(rep.head_tag), 16'(data[16:1]));
			compare_field("head_age", 16'(rep.head_age), 16'(data[24:17]));
			compare_field("head_priority", 16'(rep.head_prio), 16'(data[32:25]));
			compare_field("entry_count", 16'(rep.count), 16'(data[37:33]));
			compare_field("status", 16'(rep.status), 16'(data[39:38]));
		endfunction

		function int pending_count();
			return awaited.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	// Set for a stretch of the run in which neither side idles.
	logic calm = 1'b0;
	// Raised by the stimulus to ask the receiver for a long hold-off.
	logic long_hold_req = 1'b0;

	queue_scoreboard sb = new();

	sorted_priority_queue_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // entry_tag[15:0], entry_age[23:16], entry_priority[31:24]
		.s_tuser  (s_tuser),   // kind[0]
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // head_valid[0], head_tag[16:1], head_age[24:17],
		                       // head_priority[32:25], entry_count[37:33], status[39:38]
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both handshakes are sampled at the rising edge; inputs only move at the
	// falling edge, so the values seen here are settled.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (arst_n && s_tvalid && s_tready)
			sb.note_word(spq_pkg::kind_t'(s_tuser[0]), s_tdata);
	end

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 37);
			end
		end
	end

	// Offers one word, after a random gap, and returns once it is accepted.
	task automatic send_word(spq_pkg::kind_t kind, logic [15:0] tag, logic [7:0] age,
			logic [7:0] prio);
		int gap;
		gap = 0;
		while (!calm && $urandom_range(99) < 37)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {prio, age, tag};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Stops offering and waits until every awaited report has come back.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending_count() != 0)
			@(posedge clk);
	endtask

	initial begin
		int             push_bias;
		spq_pkg::kind_t kind;
		logic [7:0]     age;
		logic [7:0]     prio;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. A pop of the empty queue reports an empty head and
		// the empty-pop status.
		send_word(spq_pkg::KIND_POP, 16'hFFFF, 8'hFF, 8'hFF);
		// Field extremes, then ties broken by age and by arrival order.
		send_word(spq_pkg::KIND_PUSH, 16'hFFFF, 8'hFF, 8'hFF);
		send_word(spq_pkg::KIND_PUSH, 16'h0000, 8'h00, 8'h00);
		send_word(spq_pkg::KIND_PUSH, 16'h1234, 8'd10, 8'd5);
		send_word(spq_pkg::KIND_PUSH, 16'h1235, 8'd10, 8'd5);
		send_word(spq_pkg::KIND_PUSH, 16'h1236, 8'd20, 8'd5);
		send_word(spq_pkg::KIND_PUSH, 16'h1237, 8'd0, 8'd5);
		send_word(spq_pkg::KIND_PUSH, 16'hA5A5, 8'hFF, 8'h00);
		send_word(spq_pkg::KIND_PUSH, 16'h5A5A, 8'hFF, 8'h00);
		// Fill the remaining slots, then push once more into the full queue.
		for (int i = 0; i < 8; i++)
			send_word(spq_pkg::KIND_PUSH, 16'($urandom), 8'($urandom),
				8'($urandom_range(8)));
		send_word(spq_pkg::KIND_PUSH, 16'hBEEF, 8'hFF, 8'h00);
		repeat (3) send_word(spq_pkg::KIND_POP, 16'($urandom), 8'($urandom), 8'($urandom));

		// Random part: the push share changes every fifty words so that the
		// queue swings between full and empty; narrow ranges make ties common.
		push_bias = 50;
		for (int n = 0; n < 600; n++) begin
			if (n % 50 == 0) begin
				case ($urandom_range(4))
					0: push_bias = 10;
					1: push_bias = 30;
					2: push_bias = 50;
					3: push_bias = 75;
					default: push_bias = 92;
				endcase
			end
			calm = (n >= 300 && n < 400);
			if (n == 150)
				long_hold_req = 1'b1;
			if (n == 450)
				drain_results();
			kind = ($urandom_range(99) < push_bias) ? spq_pkg::KIND_PUSH : spq_pkg::KIND_POP;
			age  = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(2));
			case ($urandom_range(3))
				0: prio = 8'($urandom);
				1: prio = 8'($urandom_range(255, 252));
				default: prio = 8'($urandom_range(3));
			endcase
			send_word(kind, 16'($urandom), age, prio);
		end

		drain_results();
		repeat (5) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Safety limit, far above the slowest correct run.
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule

// File: sim.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_unit.sv
tb/testbench.sv
